>>> rtl/pidsc_pkg.sv
package pidsc_pkg;

  // Field and datapath widths.
  localparam int unsigned GainW    = 16;
  localparam int unsigned SpeedW   = 16;
  localparam int unsigned DtW      = 21;
  localparam int unsigned DtUsedW  = 20;
  localparam int unsigned ErrW     = 17;
  localparam int unsigned DerrW    = 18;
  localparam int unsigned LimitW   = 39;
  localparam int unsigned IntegW   = 40;
  localparam int unsigned IncW     = 33;
  localparam int unsigned DerivW   = 38;
  localparam int unsigned MulW     = 22;
  localparam int unsigned ProdW    = 44;
  localparam int unsigned AccW     = 56;
  localparam int unsigned SplitW   = 20;
  localparam int unsigned Q16W     = 16;
  localparam int unsigned FracW    = 8;
  localparam int unsigned IncMagW  = 36;
  localparam int unsigned DerMagW  = 37;

  // Divider geometry: the quotient is produced two bits per cycle.
  localparam int unsigned NumW     = 52;
  localparam int unsigned QuotW    = 38;
  localparam int unsigned DivW     = 20;

  localparam logic [DtW-1:0] UsPerSec = 21'd1000000;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 39;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_KP      = 3'd0,
    CFG_KI      = 3'd1,
    CFG_KD      = 3'd2,
    CFG_OUT_MIN = 3'd3,
    CFG_OUT_MAX = 3'd4,
    CFG_AWU     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [GainW-1:0]  kp;
    logic signed [GainW-1:0]  ki;
    logic signed [GainW-1:0]  kd;
    logic signed [SpeedW-1:0] out_min;
    logic signed [SpeedW-1:0] out_max;
    logic [LimitW-1:0]        awu_limit;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    kp:        16'sd256,
    ki:        16'sd0,
    kd:        16'sd0,
    out_min:   -16'sd100,
    out_max:   16'sd100,
    awu_limit: 39'd6553600
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_EDT,
    ST_DIV1_GO,
    ST_DIV1_WAIT,
    ST_INTEG,
    ST_MI_LO,
    ST_MI_HI,
    ST_MI_SH,
    ST_MP,
    ST_DIV2_WAIT,
    ST_DERIV,
    ST_MD_LO,
    ST_MD_HI,
    ST_MD_ADD,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    MUL_ERR_DT  = 3'd0,
    MUL_DERR_US = 3'd1,
    MUL_KI_LO   = 3'd2,
    MUL_KI_HI   = 3'd3,
    MUL_KP_ERR  = 3'd4,
    MUL_KD_LO   = 3'd5,
    MUL_KD_HI   = 3'd6
  } mul_sel_e;

  typedef enum logic {
    DIV_INC   = 1'b0,
    DIV_DERIV = 1'b1
  } div_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD        = 3'd0,
    ACC_LOAD        = 3'd1,
    ACC_ADD         = 3'd2,
    ACC_ADD_HI      = 3'd3,
    ACC_ADD_HI_SH16 = 3'd4
  } acc_op_e;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     div_start;
    div_sel_e div_sel;
    logic     integ_upd;
    logic     deriv_upd;
    acc_op_e  acc_op;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } sts_t;

endpackage

>>> rtl/pidsc_div.sv
module pidsc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pidsc_pkg::NumW-1:0]  num_i,
  input  logic [pidsc_pkg::DivW-1:0]  den_i,
  output logic                        busy_o,
  output logic [pidsc_pkg::QuotW-1:0] quot_o
);
  import pidsc_pkg::*;

  localparam int unsigned Iters = QuotW / 2;
  localparam int unsigned CntW  = $clog2(Iters);

  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DivW-1:0]   rem_q, rem_d;
  logic [DivW-1:0]   den_q;
  logic [QuotW-1:0]  work_q, work_d;

  logic [DivW:0]     t1, t2;
  logic [DivW:0]     r1, r2;
  logic              ge1, ge2;
  logic [QuotW-1:0]  w1;

  // Two restoring steps per cycle. The partial remainder always stays
  // below the divisor, so it fits the divisor's width.
  always_comb begin
    t1  = {rem_q, work_q[QuotW-1]};
    ge1 = (t1 >= {1'b0, den_q});
    r1  = ge1 ? (t1 - {1'b0, den_q}) : t1;
    w1  = {work_q[QuotW-2:0], ge1};
    t2  = {r1[DivW-1:0], w1[QuotW-1]};
    ge2 = (t2 >= {1'b0, den_q});
    r2  = ge2 ? (t2 - {1'b0, den_q}) : t2;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    work_d = work_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = DivW'(num_i[NumW-1:QuotW]);
      work_d = num_i[QuotW-1:0];
    end else if (busy_q) begin
      rem_d  = r2[DivW-1:0];
      work_d = {w1[QuotW-2:0], ge2};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(Iters - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    work_q <= work_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = work_q;

endmodule

>>> rtl/pidsc_dp.sv
module pidsc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pidsc_pkg::cmd_t                     cmd_i,
  input  pidsc_pkg::cfg_t                     cfg_i,
  input  logic signed [pidsc_pkg::SpeedW-1:0] target_speed_i,
  input  logic signed [pidsc_pkg::SpeedW-1:0] measured_speed_i,
  input  logic [pidsc_pkg::DtW-1:0]           dt_us_i,
  output pidsc_pkg::sts_t                     sts_o,
  output logic signed [pidsc_pkg::SpeedW-1:0] drive_value_o
);
  import pidsc_pkg::*;

  localparam int unsigned ValW = AccW - FracW;

  logic signed [ErrW-1:0]    err_q, err_d;
  logic [DtUsedW-1:0]        dt_q, dt_d;
  logic signed [ErrW-1:0]    prev_q;
  logic signed [IntegW-1:0]  integ_q, integ_d;
  logic signed [DerivW-1:0]  deriv_q, deriv_d;
  logic signed [MulW-1:0]    mul_a, mul_b;
  logic signed [ProdW-1:0]   mul_p, prod_q;
  logic [ProdW-1:0]          prod_mag;
  logic                      neg_q;
  logic signed [AccW-1:0]    acc_q, acc_d, prod_ext, prod_hi, acc_sum;
  logic signed [SpeedW-1:0]  drive_q, drive_d;
  logic signed [DerrW-1:0]   derr;
  logic [NumW-1:0]           div_num;
  logic [DivW-1:0]           div_den;
  logic                      div_busy;
  logic [QuotW-1:0]          quot;
  logic signed [IncW-1:0]    inc_pos, inc;
  logic signed [IntegW:0]    sum, lim, nlim;
  logic signed [DerivW-1:0]  der_pos;
  logic signed [ValW-1:0]    val, omax, omin;

  // Input capture: elapsed times over one second count as zero.
  always_comb begin
    err_d = {target_speed_i[SpeedW-1], target_speed_i}
          - {measured_speed_i[SpeedW-1], measured_speed_i};
    dt_d  = (dt_us_i > UsPerSec) ? '0 : dt_us_i[DtUsedW-1:0];
  end

  assign derr = {err_q[ErrW-1], err_q} - {prev_q[ErrW-1], prev_q};

  // Shared multiplier. Wide operands are split into a signed upper part
  // and an unsigned lower part of SplitW bits.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_ERR_DT: begin
        mul_a = {{(MulW-ErrW){err_q[ErrW-1]}}, err_q};
        mul_b = {{(MulW-DtUsedW){1'b0}}, dt_q};
      end
      MUL_DERR_US: begin
        mul_a = {{(MulW-DerrW){derr[DerrW-1]}}, derr};
        mul_b = {{(MulW-DtW){1'b0}}, UsPerSec};
      end
      MUL_KI_LO: begin
        mul_a = {{(MulW-GainW){cfg_i.ki[GainW-1]}}, cfg_i.ki};
        mul_b = {{(MulW-SplitW){1'b0}}, integ_q[SplitW-1:0]};
      end
      MUL_KI_HI: begin
        mul_a = {{(MulW-GainW){cfg_i.ki[GainW-1]}}, cfg_i.ki};
        mul_b = {{(MulW-IntegW+SplitW){integ_q[IntegW-1]}}, integ_q[IntegW-1:SplitW]};
      end
      MUL_KP_ERR: begin
        mul_a = {{(MulW-GainW){cfg_i.kp[GainW-1]}}, cfg_i.kp};
        mul_b = {{(MulW-ErrW){err_q[ErrW-1]}}, err_q};
      end
      MUL_KD_LO: begin
        mul_a = {{(MulW-GainW){cfg_i.kd[GainW-1]}}, cfg_i.kd};
        mul_b = {{(MulW-SplitW){1'b0}}, deriv_q[SplitW-1:0]};
      end
      MUL_KD_HI: begin
        mul_a = {{(MulW-GainW){cfg_i.kd[GainW-1]}}, cfg_i.kd};
        mul_b = {{(MulW-DerivW+SplitW){deriv_q[DerivW-1]}}, deriv_q[DerivW-1:SplitW]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Both divisions work on magnitudes and the sign is put back afterwards,
  // which gives truncation toward zero.
  assign prod_mag = prod_q[ProdW-1] ? -prod_q : prod_q;

  always_comb begin
    if (cmd_i.div_sel == DIV_INC) begin
      div_num = {prod_mag[IncMagW-1:0], {Q16W{1'b0}}};
      div_den = UsPerSec[DivW-1:0];
    end else begin
      div_num = {{(NumW-DerMagW){1'b0}}, prod_mag[DerMagW-1:0]};
      div_den = dt_q;
    end
  end

  pidsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  assign sts_o.div_busy = div_busy;

  // Integral update with clamping to the anti-windup bound.
  always_comb begin
    inc_pos = {1'b0, quot[IncW-2:0]};
    inc     = neg_q ? -inc_pos : inc_pos;
    sum     = {integ_q[IntegW-1], integ_q} + {{(IntegW+1-IncW){inc[IncW-1]}}, inc};
    lim     = {2'b00, cfg_i.awu_limit};
    nlim    = -lim;
    if (sum > lim) begin
      integ_d = lim[IntegW-1:0];
    end else if (sum < nlim) begin
      integ_d = nlim[IntegW-1:0];
    end else begin
      integ_d = sum[IntegW-1:0];
    end
  end

  // The derivative is zero when no time has passed.
  always_comb begin
    der_pos = {1'b0, quot[DerMagW-1:0]};
    if (dt_q == '0) begin
      deriv_d = '0;
    end else begin
      deriv_d = neg_q ? -der_pos : der_pos;
    end
  end

  // Accumulator for the three weighted terms.
  always_comb begin
    prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
    prod_hi  = {prod_ext[AccW-1-SplitW:0], {SplitW{1'b0}}};
    acc_sum  = acc_q + ((cmd_i.acc_op == ACC_ADD) ? prod_ext : prod_hi);
    case (cmd_i.acc_op)
      ACC_HOLD:        acc_d = acc_q;
      ACC_LOAD:        acc_d = prod_ext;
      ACC_ADD:         acc_d = acc_sum;
      ACC_ADD_HI:      acc_d = acc_sum;
      ACC_ADD_HI_SH16: acc_d = {{Q16W{acc_sum[AccW-1]}}, acc_sum[AccW-1:Q16W]};
      default:         acc_d = acc_q;
    endcase
  end

  // Output scaling and saturation; the upper limit is tested first.
  always_comb begin
    val  = acc_q[AccW-1:FracW];
    omax = {{(ValW-SpeedW){cfg_i.out_max[SpeedW-1]}}, cfg_i.out_max};
    omin = {{(ValW-SpeedW){cfg_i.out_min[SpeedW-1]}}, cfg_i.out_min};
    if (val > omax) begin
      drive_d = cfg_i.out_max;
    end else if (val < omin) begin
      drive_d = cfg_i.out_min;
    end else begin
      drive_d = val[SpeedW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else begin
      if (cmd_i.integ_upd) begin
        integ_q <= integ_d;
      end
      if (cmd_i.out_load) begin
        prev_q <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      err_q <= err_d;
      dt_q  <= dt_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
    if (cmd_i.div_start) begin
      neg_q <= prod_q[ProdW-1];
    end
    if (cmd_i.deriv_upd) begin
      deriv_q <= deriv_d;
    end
    acc_q <= acc_d;
    if (cmd_i.out_load) begin
      drive_q <= drive_d;
    end
  end

  assign drive_value_o = drive_q;

endmodule

>>> rtl/pidsc_ctrl.sv
module pidsc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_stall_i,
  input  pidsc_pkg::sts_t sts_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output pidsc_pkg::cmd_t cmd_o
);
  import pidsc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_MUL_EDT;
        end
      end
      ST_MUL_EDT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ERR_DT;
        state_d       = ST_DIV1_GO;
      end
      ST_DIV1_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_INC;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_DERR_US;
        state_d         = ST_DIV1_WAIT;
      end
      ST_DIV1_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = ST_INTEG;
        end
      end
      ST_INTEG: begin
        cmd_o.integ_upd = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_DERIV;
        state_d         = ST_MI_LO;
      end
      ST_MI_LO: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KI_LO;
        state_d       = ST_MI_HI;
      end
      ST_MI_HI: begin
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KI_HI;
        state_d       = ST_MI_SH;
      end
      ST_MI_SH: begin
        cmd_o.acc_op  = ACC_ADD_HI_SH16;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KP_ERR;
        state_d       = ST_MP;
      end
      ST_MP: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = ST_DIV2_WAIT;
      end
      ST_DIV2_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = ST_DERIV;
        end
      end
      ST_DERIV: begin
        cmd_o.deriv_upd = 1'b1;
        state_d         = ST_MD_LO;
      end
      ST_MD_LO: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KD_LO;
        state_d       = ST_MD_HI;
      end
      ST_MD_HI: begin
        cmd_o.acc_op  = ACC_ADD;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KD_HI;
        state_d       = ST_MD_ADD;
      end
      ST_MD_ADD: begin
        cmd_o.acc_op = ACC_ADD_HI;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/pid_speed_controller.sv
// PID speed controller with anti-windup, one sample word at a time.
// A new input word is accepted only after the previous word's result has
// been loaded into the output register, which waits while the output side
// stalls; the shared divider (two quotient bits a cycle) runs twice per word.
// Reset: gains and limits return to their defaults, the integral and the
// previous error clear, and both channels come up empty.
module pid_speed_controller (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pidsc_pkg::CfgAddrW-1:0]        cfg_addr_i,
  input  logic [pidsc_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [pidsc_pkg::SpeedW-1:0]   target_speed_i,
  input  logic signed [pidsc_pkg::SpeedW-1:0]   measured_speed_i,
  input  logic [pidsc_pkg::DtW-1:0]             dt_us_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [pidsc_pkg::SpeedW-1:0]   drive_value_o
);
  import pidsc_pkg::*;

  // Configuration registers. Writes are only expected while the block is
  // idle, so the datapath reads them directly without a shadow copy. An
  // index beyond the last register is simply ignored.
  cfg_t cfg_q;

  // Command and status between the sequencer and the datapath.
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_KP:      cfg_q.kp        <= cfg_wdata_i[GainW-1:0];
        CFG_KI:      cfg_q.ki        <= cfg_wdata_i[GainW-1:0];
        CFG_KD:      cfg_q.kd        <= cfg_wdata_i[GainW-1:0];
        CFG_OUT_MIN: cfg_q.out_min   <= cfg_wdata_i[SpeedW-1:0];
        CFG_OUT_MAX: cfg_q.out_max   <= cfg_wdata_i[SpeedW-1:0];
        CFG_AWU:     cfg_q.awu_limit <= cfg_wdata_i[LimitW-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // The sequencer walks one word through these steps:
  //   capture error and elapsed time, form error*dt, divide it by one
  //   million (scaled to Q16) to get the integral increment, update and
  //   clamp the integral, then divide (error change)*1e6 by dt for the
  //   derivative. While the second division runs, the integral and
  //   proportional terms are accumulated. The derivative term follows,
  //   and the sum is scaled down by 8 bits and saturated into the output
  //   register, which holds the word until the consumer takes it.
  pidsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // The datapath holds one multiplier, the shared divider, the
  // accumulator and the controller state (integral and previous error).
  pidsc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg_q),
    .target_speed_i   (target_speed_i),
    .measured_speed_i (measured_speed_i),
    .dt_us_i          (dt_us_i),
    .sts_o            (sts),
    .drive_value_o    (drive_value_o)
  );

endmodule

>>> rtl/pidsc_checker.sv
module pidsc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [pidsc_pkg::SpeedW-1:0] drive_value_o
);

  // A stalled result word stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_value_o))
    else $error("result word changed or dropped while stalled");

  // The block works on one word at a time: after taking a word it is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a word was accepted");

  // A fresh result only appears at the end of a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word appeared without a word being worked on");

endmodule

bind pid_speed_controller pidsc_checker u_pidsc_checker (.*);
